// ===== rtl/core/ssll_pkg.sv =====
// Shared types, codes and default sizes for the sorted linked list block.
package ssll_pkg;

  // Default sizes handed to the top level parameters
  localparam int unsigned NODES_DEF        = 16;
  localparam int unsigned KEY_BITS_DEF     = 16;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  // Fixed widths of the command and result fields
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUPLICATE = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_DECIDE,
    S_FREE,
    S_POP,
    S_LINK,
    S_DONE
  } state_e;

  // Source of the node memory read address
  typedef enum logic [1:0] {
    RD_HEAD,
    RD_LINK,
    RD_FREE
  } rd_sel_e;

  // Source of the reported slot
  typedef enum logic [1:0] {
    SLOT_NONE,
    SLOT_CUR,
    SLOT_NEW
  } slot_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      capture;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      walk_init;
    logic      walk_step;
    logic      clear;
    logic      unlink_a;
    logic      unlink_b;
    logic      pop;
    logic      link_new;
    logic      res_load;
    status_e   res_status;
    slot_sel_e res_slot;
    logic      res_pay;
    logic      out_load;
  } ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    cmd_e cmd;
    logic free_empty;
    logic head_end;
    logic walk_cont;
    logic hit;
    logic out_free;
  } stat_t;

endpackage

// ===== rtl/core/ssll_req_if.sv =====
// Command channel: valid/ready handshake carrying one list command per beat.
interface ssll_req_if import ssll_pkg::*; #(
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, cmd, key, payload, input ready);
  modport sink   (input valid, cmd, key, payload, output ready);
endinterface

// ===== rtl/core/ssll_rsp_if.sv =====
// Result channel: valid/ready handshake carrying one command result per beat.
interface ssll_rsp_if import ssll_pkg::*; #(
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic [SLOT_W-1:0]       slot;
  logic [PAYLOAD_BITS-1:0] found_payload;
  logic [COUNT_W-1:0]      count;

  modport source (output valid, status, slot, found_payload, count, input ready);
  modport sink   (input valid, status, slot, found_payload, count, output ready);
endinterface

// ===== rtl/core/ssll_ctrl.sv =====
// Controller state machine sequencing walk, relink and result steps per command.
module ssll_ctrl import ssll_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    req_ready_o = 1'b0;
    ctrl_o      = '0;
    ctrl_o.rd_sel     = RD_HEAD;
    ctrl_o.res_status = ST_OK;
    ctrl_o.res_slot   = SLOT_NONE;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_START;
        end
      end
      S_START: begin
        priority if (stat_i.cmd == CMD_CLEAR) begin
          ctrl_o.clear    = 1'b1;
          ctrl_o.res_load = 1'b1;
          state_d         = S_DONE;
        end else if (stat_i.cmd == CMD_INSERT && stat_i.free_empty) begin
          ctrl_o.res_load   = 1'b1;
          ctrl_o.res_status = ST_FULL;
          state_d           = S_DONE;
        end else if (stat_i.head_end) begin
          ctrl_o.walk_init = 1'b1;
          state_d          = S_DECIDE;
        end else begin
          ctrl_o.walk_init = 1'b1;
          ctrl_o.rd_en     = 1'b1;
          ctrl_o.rd_sel    = RD_HEAD;
          state_d          = S_WALK;
        end
      end
      S_WALK: begin
        // One node per cycle; read the successor while it is still below the key
        ctrl_o.walk_step = 1'b1;
        if (stat_i.walk_cont) begin
          ctrl_o.rd_en  = 1'b1;
          ctrl_o.rd_sel = RD_LINK;
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat_i.cmd)
          CMD_SEARCH: begin
            ctrl_o.res_load   = 1'b1;
            ctrl_o.res_status = stat_i.hit ? ST_OK : ST_NOT_FOUND;
            ctrl_o.res_slot   = stat_i.hit ? SLOT_CUR : SLOT_NONE;
            ctrl_o.res_pay    = stat_i.hit;
            state_d           = S_DONE;
          end
          CMD_REMOVE: begin
            if (stat_i.hit) begin
              ctrl_o.unlink_a = 1'b1;
              state_d         = S_FREE;
            end else begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = ST_NOT_FOUND;
              state_d           = S_DONE;
            end
          end
          CMD_INSERT: begin
            if (stat_i.hit) begin
              ctrl_o.res_load   = 1'b1;
              ctrl_o.res_status = ST_DUPLICATE;
              state_d           = S_DONE;
            end else begin
              ctrl_o.rd_en  = 1'b1;
              ctrl_o.rd_sel = RD_FREE;
              state_d       = S_POP;
            end
          end
          CMD_CLEAR: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_FREE: begin
        ctrl_o.unlink_b = 1'b1;
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_slot = SLOT_CUR;
        state_d         = S_DONE;
      end
      S_POP: begin
        ctrl_o.pop = 1'b1;
        state_d    = S_LINK;
      end
      S_LINK: begin
        ctrl_o.link_new = 1'b1;
        ctrl_o.res_load = 1'b1;
        ctrl_o.res_slot = SLOT_NEW;
        state_d         = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register once it is free
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/ssll_dp.sv =====
// Datapath: node memories, list pointers, walk registers and result register.
module ssll_dp import ssll_pkg::*; #(
  parameter int unsigned NODES        = NODES_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctrl_t                   ctrl_i,
  output stat_t                   stat_o,
  input  logic [CMD_W-1:0]        cmd_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [PAYLOAD_BITS-1:0] payload_i,
  output logic                    rsp_valid_o,
  input  logic                    rsp_ready_i,
  output logic [STATUS_W-1:0]     status_o,
  output logic [SLOT_W-1:0]       slot_o,
  output logic [PAYLOAD_BITS-1:0] found_payload_o,
  output logic [COUNT_W-1:0]      count_o
);

  localparam int unsigned LINK_W = $clog2(NODES + 1);
  localparam int unsigned IDX_W  = $clog2(NODES);
  localparam logic [LINK_W-1:0] END_MARK = LINK_W'(NODES);
  localparam logic [LINK_W-1:0] LAST_STEP = LINK_W'(NODES - 1);

  // Node memories
  logic [LINK_W-1:0]       link_mem_q [NODES];
  logic [KEY_BITS-1:0]     key_mem_q  [NODES];
  logic [PAYLOAD_BITS-1:0] pay_mem_q  [NODES];
  logic [LINK_W-1:0]       link_rd_q;
  logic [KEY_BITS-1:0]     key_rd_q;
  logic [PAYLOAD_BITS-1:0] pay_rd_q;

  // Captured command
  cmd_e                    cmd_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  // List pointers; nodes at or above fill_q were never taken since the last clear
  logic [LINK_W-1:0] head_q;
  logic [LINK_W-1:0] free_q;
  logic [LINK_W-1:0] fill_q;
  logic [LINK_W-1:0] count_q;

  // Walk registers
  logic [LINK_W-1:0]       cur_q;
  logic [LINK_W-1:0]       prev_q;
  logic [LINK_W-1:0]       steps_q;
  logic [LINK_W-1:0]       cur_link_q;
  logic [LINK_W-1:0]       new_q;
  logic                    hit_q;
  logic [PAYLOAD_BITS-1:0] fpay_q;

  // Result and output registers
  status_e                 res_status_q;
  logic [IDX_W-1:0]        res_slot_q;
  logic [PAYLOAD_BITS-1:0] res_pay_q;
  logic                    out_valid_q;
  logic [STATUS_W-1:0]     out_status_q;
  logic [SLOT_W-1:0]       out_slot_q;
  logic [PAYLOAD_BITS-1:0] out_pay_q;
  logic [COUNT_W-1:0]      out_count_q;

  logic [LINK_W-1:0] rd_ptr;
  logic [IDX_W-1:0]  rd_idx;
  logic              link_we;
  logic [IDX_W-1:0]  link_wa;
  logic [LINK_W-1:0] link_wd;
  logic              key_less;
  logic              key_eq;
  logic              prev_end;
  logic              pop_fresh;

  assign key_less  = key_rd_q < key_q;
  assign key_eq    = key_rd_q == key_q;
  assign prev_end  = prev_q >= END_MARK;
  assign pop_fresh = free_q == fill_q;

  // Select the read address
  always_comb begin
    unique case (ctrl_i.rd_sel)
      RD_HEAD: rd_ptr = head_q;
      RD_LINK: rd_ptr = link_rd_q;
      default: rd_ptr = free_q;
    endcase
    rd_idx = rd_ptr[IDX_W-1:0];
  end

  // Select the link write
  always_comb begin
    link_we = 1'b0;
    link_wa = prev_q[IDX_W-1:0];
    link_wd = cur_link_q;
    priority if (ctrl_i.unlink_a) begin
      link_we = !prev_end;
    end else if (ctrl_i.unlink_b) begin
      link_we = 1'b1;
      link_wa = cur_q[IDX_W-1:0];
      link_wd = free_q;
    end else if (ctrl_i.pop) begin
      link_we = 1'b1;
      link_wa = free_q[IDX_W-1:0];
      link_wd = cur_q;
    end else if (ctrl_i.link_new) begin
      link_we = !prev_end;
      link_wd = new_q;
    end
  end

  // Node memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem_q[link_wa] <= link_wd;
    end
    if (ctrl_i.pop) begin
      key_mem_q[free_q[IDX_W-1:0]] <= key_q;
      pay_mem_q[free_q[IDX_W-1:0]] <= pay_q;
    end
    if (ctrl_i.rd_en) begin
      link_rd_q <= link_mem_q[rd_idx];
      key_rd_q  <= key_mem_q[rd_idx];
      pay_rd_q  <= pay_mem_q[rd_idx];
    end
  end

  // Capture the command beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q <= cmd_e'(cmd_i);
      key_q <= key_i;
      pay_q <= payload_i;
    end
  end

  // Walk: advance past smaller keys, stop at the first key not below
  always_ff @(posedge clk_i) begin
    if (ctrl_i.walk_init) begin
      cur_q   <= head_q;
      prev_q  <= END_MARK;
      steps_q <= '0;
      hit_q   <= 1'b0;
    end else if (ctrl_i.walk_step) begin
      if (key_less) begin
        prev_q  <= cur_q;
        cur_q   <= link_rd_q;
        steps_q <= steps_q + 1'b1;
      end else begin
        hit_q      <= key_eq;
        cur_link_q <= link_rd_q;
        fpay_q     <= pay_rd_q;
      end
    end
    if (ctrl_i.pop) begin
      new_q <= free_q;
    end
  end

  // List pointers and entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= END_MARK;
      free_q  <= '0;
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        head_q  <= END_MARK;
        free_q  <= '0;
        fill_q  <= '0;
        count_q <= '0;
      end
      if (ctrl_i.unlink_a && prev_end) begin
        head_q <= cur_link_q;
      end
      if (ctrl_i.unlink_b) begin
        free_q  <= cur_q;
        count_q <= count_q - 1'b1;
      end
      // Pop: an untouched node links to its neighbor, a recycled one to memory
      if (ctrl_i.pop) begin
        if (pop_fresh) begin
          free_q <= free_q + 1'b1;
          fill_q <= fill_q + 1'b1;
        end else begin
          free_q <= link_rd_q;
        end
      end
      if (ctrl_i.link_new) begin
        if (prev_end) begin
          head_q <= new_q;
        end
        count_q <= count_q + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.res_load) begin
      res_status_q <= ctrl_i.res_status;
      unique case (ctrl_i.res_slot)
        SLOT_CUR: res_slot_q <= cur_q[IDX_W-1:0];
        SLOT_NEW: res_slot_q <= new_q[IDX_W-1:0];
        default:  res_slot_q <= '0;
      endcase
      res_pay_q <= ctrl_i.res_pay ? fpay_q : '0;
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
      out_pay_q    <= res_pay_q;
      out_count_q  <= COUNT_W'(count_q);
    end
  end

  assign rsp_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign slot_o          = out_slot_q;
  assign found_payload_o = out_pay_q;
  assign count_o         = out_count_q;

  // Status to the controller
  assign stat_o.cmd        = cmd_q;
  assign stat_o.free_empty = free_q >= END_MARK;
  assign stat_o.head_end   = head_q >= END_MARK;
  assign stat_o.walk_cont  = key_less && (link_rd_q < END_MARK) && (steps_q < LAST_STEP);
  assign stat_o.hit        = hit_q;
  assign stat_o.out_free   = !out_valid_q || rsp_ready_i;

endmodule

// ===== rtl/core/sorted_static_linked_list.sv =====
// Top level of the sorted linked list: one command beat in, one result beat out.
// Clear and insert when full skip the walk; search, remove and insert walk the list,
// reading W nodes (0 to NODES), one node per cycle from the node memories.
// One command at a time; the next beat is taken the cycle after the output loads.
// Reset is immediate: the free chain is tracked by a fill mark, so no memory pass.
module sorted_static_linked_list import ssll_pkg::*; #(
  parameter int unsigned NODES        = NODES_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssll_req_if.sink    req_i,
  ssll_rsp_if.source  rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequence each command
  ssll_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Hold the list and the result
  ssll_dp #(
    .NODES        (NODES),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .cmd_i           (req_i.cmd),
    .key_i           (req_i.key),
    .payload_i       (req_i.payload),
    .rsp_valid_o     (rsp_o.valid),
    .rsp_ready_i     (rsp_o.ready),
    .status_o        (rsp_o.status),
    .slot_o          (rsp_o.slot),
    .found_payload_o (rsp_o.found_payload),
    .count_o         (rsp_o.count)
  );

endmodule
